// ===== rtl/cpt_pkg.sv =====
// ============================================================================
// cpt_pkg: shared types and constants of the codepage transcoder
// Encoding codes, configuration register indexes, queue depth and the
// structs passed between the front, the queue and the back.
// ============================================================================
package cpt_pkg;

  // source encodings
  localparam logic [1:0] IN_RAW     = 2'd0;
  localparam logic [1:0] IN_UTF8    = 2'd1;
  localparam logic [1:0] IN_CP1251  = 2'd2;
  localparam logic [1:0] IN_UTF16LE = 2'd3;

  // target encodings; codes five to seven behave as raw
  localparam logic [2:0] OUT_RAW     = 3'd0;
  localparam logic [2:0] OUT_UTF8    = 3'd1;
  localparam logic [2:0] OUT_CP1251  = 3'd2;
  localparam logic [2:0] OUT_UTF16LE = 3'd3;
  localparam logic [2:0] OUT_UTF16BE = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_IN_CODE      = 2'd0;
  localparam logic [1:0] REG_OUT_CODE     = 2'd1;
  localparam logic [1:0] REG_OUTPUT_LIMIT = 2'd2;

  // reset values of the registers
  localparam logic [1:0]  IN_CODE_RST      = IN_UTF8;
  localparam logic [2:0]  OUT_CODE_RST     = OUT_UTF8;
  localparam logic [15:0] OUTPUT_LIMIT_RST = 16'hFFFF;

  // room for the bytes of one source byte: up to three for a character, up to two zeros
  localparam int MaxBytes  = 5;
  localparam int CntW      = $clog2(MaxBytes + 1);
  localparam int IdxW      = $clog2(MaxBytes);
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  typedef struct packed {
    logic [1:0]  in_code;
    logic [2:0]  out_code;
    logic [15:0] output_limit;
  } cpt_cfg_t;

  // one queued job: the bytes to send for one source byte, first in [0]
  typedef struct packed {
    logic [CntW-1:0]           count;
    logic [MaxBytes-1:0][7:0]  bytes;
  } cpt_job_t;

endpackage

// ===== rtl/cpt_front.sv =====
// ============================================================================
// cpt_front: decode, encode and budget stage
// Takes one source byte per transfer, tracks the partial character and the
// output byte budget, and builds the complete byte job for the queue.
// ============================================================================
module cpt_front (
  input  logic               clk,
  input  logic               rst,
  input  cpt_pkg::cpt_cfg_t  cfg,
  input  logic               clear,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic               q_full,
  output logic               in_ready,
  output logic               push,
  output cpt_pkg::cpt_job_t  job
);
  import cpt_pkg::*;

  logic [15:0] partial_char, partial_char_next;
  logic [1:0]  bytes_left, bytes_left_next;
  logic [15:0] bytes_emitted, bytes_emitted_next;

  logic        have;
  logic [15:0] ch;
  logic [2:0][7:0] cb;
  logic [1:0]  ck;
  logic        emit;
  logic [16:0] sum1;
  logic [15:0] e1;
  logic [16:0] sum2;
  logic [15:0] e2;
  logic        term1, term2;
  logic        accept;

  function automatic logic [15:0] from_cp1251(input logic [7:0] b);
    logic [15:0] r;
    r = {8'h00, b};
    if (b >= 8'hC0) r = {8'h00, b} + 16'h0350;
    else begin
      case (b)
        8'hB2:   r = 16'h0406;
        8'hAF:   r = 16'h0407;
        8'hB3:   r = 16'h0456;
        8'hBF:   r = 16'h0457;
        default: r = {8'h00, b};
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] to_cp1251(input logic [15:0] v);
    logic [15:0] d;
    logic [7:0]  r;
    d = v - 16'h0350;
    r = v[7:0];
    if (v >= 16'h0410 && v <= 16'h044F) r = d[7:0];
    else begin
      case (v)
        16'h0406: r = 8'hB2;
        16'h0407: r = 8'hAF;
        16'h0456: r = 8'hB3;
        16'h0457: r = 8'hBF;
        default:  r = v[7:0];
      endcase
    end
    return r;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // decode
  always_comb begin
    partial_char_next = partial_char;
    bytes_left_next   = bytes_left;
    have = 1'b0;
    ch   = 16'h0000;
    case (cfg.in_code)
      IN_UTF8: begin
        if (bytes_left == 2'd0) begin
          if (in_byte inside {[8'd192:8'd223]}) begin
            partial_char_next = {8'h00, in_byte - 8'd192};
            bytes_left_next   = 2'd1;
          end else if (in_byte inside {[8'd224:8'd239]}) begin
            partial_char_next = {8'h00, in_byte - 8'd224};
            bytes_left_next   = 2'd2;
          end else begin
            ch   = {8'h00, in_byte};
            have = 1'b1;
          end
        end else begin
          // continuation bytes are not checked
          partial_char_next = {partial_char[9:0], 6'b0} + {8'h00, in_byte} - 16'd128;
          bytes_left_next   = bytes_left - 2'd1;
          if (bytes_left == 2'd1) begin
            ch   = partial_char_next;
            have = 1'b1;
          end
        end
      end
      IN_CP1251: begin
        ch   = from_cp1251(in_byte);
        have = 1'b1;
      end
      IN_UTF16LE: begin
        if (bytes_left == 2'd0) begin
          partial_char_next = {8'h00, in_byte};
          bytes_left_next   = 2'd1;
        end else begin
          ch   = {in_byte, partial_char[7:0]};
          bytes_left_next = 2'd0;
          have = 1'b1;
        end
      end
      default: begin
        ch   = {8'h00, in_byte};
        have = 1'b1;
      end
    endcase
  end

  // encode
  always_comb begin
    cb = '0;
    ck = 2'd1;
    case (cfg.out_code)
      OUT_UTF8: begin
        if (ch < 16'd128) begin
          cb[0] = ch[7:0];
        end else if (ch < 16'd2048) begin
          cb[0] = 8'd192 + {3'b000, ch[10:6]};
          cb[1] = 8'd128 + {2'b00, ch[5:0]};
          ck    = 2'd2;
        end else begin
          cb[0] = 8'd224 + {4'h0, ch[15:12]};
          cb[1] = 8'd128 + {2'b00, ch[11:6]};
          cb[2] = 8'd128 + {2'b00, ch[5:0]};
          ck    = 2'd3;
        end
      end
      OUT_CP1251: cb[0] = to_cp1251(ch);
      OUT_UTF16LE: begin
        cb[0] = ch[7:0];
        cb[1] = ch[15:8];
        ck    = 2'd2;
      end
      OUT_UTF16BE: begin
        cb[0] = ch[15:8];
        cb[1] = ch[7:0];
        ck    = 2'd2;
      end
      default: cb[0] = ch[7:0];
    endcase
  end

  // budget: a character starts only below the limit, then may overshoot
  always_comb begin
    emit  = have && (bytes_emitted < cfg.output_limit);
    sum1  = {1'b0, bytes_emitted} + {15'b0, ck};
    e1    = bytes_emitted;
    if (emit) e1 = sum1[16] ? 16'hFFFF : sum1[15:0];
    term1 = in_last && (e1 < cfg.output_limit);
    sum2  = {1'b0, e1} + 17'd1;
    e2    = sum2[16] ? 16'hFFFF : sum2[15:0];
    term2 = term1 && (cfg.out_code == OUT_UTF16LE || cfg.out_code == OUT_UTF16BE)
            && (e2 < cfg.output_limit);
    bytes_emitted_next = in_last ? 16'h0000 : e1;
  end

  // bytes past the character are zero, which also gives the terminators
  always_comb begin
    job.bytes = '0;
    if (emit) begin
      job.bytes[0] = cb[0];
      job.bytes[1] = cb[1];
      job.bytes[2] = cb[2];
    end
    job.count = (emit ? CntW'(ck) : CntW'(0)) + CntW'(term1) + CntW'(term2);
  end

  assign push = accept && (job.count != '0);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      partial_char  <= '0;
      bytes_left    <= '0;
    end else if (accept) begin
      partial_char  <= in_last ? 16'h0000 : partial_char_next;
      bytes_left    <= in_last ? 2'd0 : bytes_left_next;
    end
    if (rst) begin
      bytes_emitted <= '0;
    end else if (accept) begin
      bytes_emitted <= bytes_emitted_next;
    end
  end

endmodule

// ===== rtl/cpt_fifo.sv =====
// ============================================================================
// cpt_fifo: job queue between front and back
// Small first-in first-out store of complete byte jobs.
// ============================================================================
module cpt_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cpt_pkg::cpt_job_t  wr_job,
  input  logic               pop,
  output cpt_pkg::cpt_job_t  rd_job,
  output logic               full,
  output logic               empty
);
  import cpt_pkg::*;

  cpt_job_t           mem [QDepth];
  logic [QPtrW-1:0]   wr_ptr;
  logic [QPtrW-1:0]   rd_ptr;
  logic [QCntW-1:0]   cnt;

  assign full   = (cnt == QCntW'(QDepth));
  assign empty  = (cnt == '0);
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPtrW'(1);
      if (pop)  rd_ptr <= rd_ptr + QPtrW'(1);
      if (push && !pop)      cnt <= cnt + QCntW'(1);
      else if (pop && !push) cnt <= cnt - QCntW'(1);
    end
  end

endmodule

// ===== rtl/cpt_back.sv =====
// ============================================================================
// cpt_back: byte serializer
// Sends the bytes of the head job one per transfer, marking the last one.
// ============================================================================
module cpt_back (
  input  logic               clk,
  input  logic               rst,
  input  cpt_pkg::cpt_job_t  head,
  input  logic               q_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last
);
  import cpt_pkg::*;

  logic [IdxW-1:0] idx;
  logic            xfer;

  assign out_valid = !q_empty;
  assign out_byte  = head.bytes[idx];
  assign out_last  = (CntW'(idx) == (head.count - CntW'(1)));
  assign xfer      = out_valid && out_ready;
  assign pop       = xfer && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop) begin
      idx <= '0;
    end else if (xfer) begin
      idx <= idx + IdxW'(1);
    end
  end

endmodule

// ===== rtl/codepage_transcoder.sv =====
// ============================================================================
// codepage_transcoder: byte-serial character transcoder
// Decodes raw, UTF-8, CP1251 or UTF-16LE source bytes and re-encodes them as
// raw, UTF-8, CP1251, UTF-16LE or UTF-16BE, with an output byte budget and a
// zero terminator on the last source byte.
// ============================================================================
// Source bytes come in on the s_axis side, one per transfer, with tlast on
// the final byte of a string. Each source byte yields zero to four output
// bytes on m_axis; tlast there marks the last byte caused by one source
// byte. The front stage accepts a source byte every cycle while its
// four-entry job queue has room; the back stage sends one output byte per
// cycle while m_axis_tready is high and the queue holds a job, so the
// sustained rate is set by the output port, which must carry every byte
// that a source byte yields (one for a plain ASCII byte, up to four for a
// three-byte UTF-8 character plus terminator or a UTF-16 unit plus two
// zeros). Configuration writes are never stalled (cfg_ready is always
// high) and must only happen while the block is idle; writing in_code
// drops any partial character.
module codepage_transcoder (
  input  logic        clk,
  input  logic        rst,
  // source bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  // encoded bytes
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // out_last
  // register writes: 0 in_code, 1 out_code, 2 output_limit
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cpt_pkg::*;

  cpt_cfg_t cfg;
  logic     cfg_wr;
  logic     clear;
  logic     q_full, q_empty;
  logic     push, pop;
  cpt_job_t wr_job, head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // a new source encoding restarts character assembly
  assign clear     = cfg_wr && (cfg_index == REG_IN_CODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_code      <= IN_CODE_RST;
      cfg.out_code     <= OUT_CODE_RST;
      cfg.output_limit <= OUTPUT_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_IN_CODE:      cfg.in_code      <= cfg_data[1:0];
        REG_OUT_CODE:     cfg.out_code     <= cfg_data[2:0];
        REG_OUTPUT_LIMIT: cfg.output_limit <= cfg_data;
        default: ;        // index beyond the list: ignored
      endcase
    end
  end

  // front: decode, encode, budget; one job per source byte
  cpt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clear    (clear),
    .in_valid (s_axis_tvalid),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_full   (q_full),
    .in_ready (s_axis_tready),
    .push     (push),
    .job      (wr_job)
  );

  // jobs with no bytes are never queued
  cpt_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  // back: one byte per transfer
  cpt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== tb/codepage_transcoder_test.sv =====
// ============================================================================
// codepage_transcoder_test: self-checking bench for the codepage transcoder
// Plays strings of source bytes through several encoding pairs and output
// budgets, predicts every encoded byte in a scoreboard and compares each
// output transfer against it, with random stalls on both stream sides.
// ============================================================================
module codepage_transcoder_test;
  import cpt_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 20;      // front stage + job queue + back stage, with margin
  localparam int LONG_HOLD      = 120;     // one long back-pressure stretch
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int MIN_PHASE_BYTES = 12;

  // index past the register list: must be ignored
  localparam logic [1:0] REG_SPARE = 2'd3;
  // target codes without a meaning of their own, sent as raw
  localparam logic [2:0] OUT_SPARE_LO = 3'd5;
  localparam logic [2:0] OUT_SPARE_HI = 3'd7;

  // one byte on either stream, with its tlast
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the registers and string state, predicts the
  // encoded bytes for each accepted source byte and keeps them in order.
  // --------------------------------------------------------------------------
  class transcode_tracker;
    logic [1:0]  in_code;
    logic [2:0]  out_code;
    logic [15:0] out_limit;
    logic [15:0] partial;      // character under assembly
    logic [1:0]  left;         // source bytes still owed for it
    logic [15:0] sent;         // bytes sent for the current string
    logic [7:0]  step_bytes[$];
    beat_t       due[$];
    int          errors;

    function new();
      in_code   = IN_CODE_RST;
      out_code  = OUT_CODE_RST;
      out_limit = OUTPUT_LIMIT_RST;
      partial   = '0;
      left      = '0;
      sent      = '0;
      errors    = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void load_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_IN_CODE: begin
          in_code = val[1:0];
          partial = '0;
          left    = '0;
        end
        REG_OUT_CODE:     out_code  = val[2:0];
        REG_OUTPUT_LIMIT: out_limit = val;
        default: ;
      endcase
    endfunction

    function logic [15:0] cp1251_to_ucs(logic [7:0] b);
      // bytes C0 to FF are the contiguous Cyrillic block, plus four Ukrainian letters
      if (b >= 8'hC0) return 16'h0410 + {8'h00, b} - 16'h00C0;
      case (b)
        8'hB2:   return 16'h0406;
        8'hAF:   return 16'h0407;
        8'hB3:   return 16'h0456;
        8'hBF:   return 16'h0457;
        default: return {8'h00, b};
      endcase
    endfunction

    function logic [7:0] ucs_to_cp1251(logic [15:0] v);
      if (v >= 16'h0410 && v <= 16'h044F) return v[7:0] - 8'h10 + 8'hC0;
      case (v)
        16'h0406: return 8'hB2;
        16'h0407: return 8'hAF;
        16'h0456: return 8'hB3;
        16'h0457: return 8'hBF;
        default:  return v[7:0];   // anything else: low byte
      endcase
    endfunction

    function void count_out(int k);
      int s;
      s = int'(sent) + k;
      sent = (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    function void encode(logic [15:0] v);
      case (out_code)
        OUT_UTF8: begin
          if (v < 16'd128) begin
            step_bytes.push_back(v[7:0]);
          end else if (v < 16'd2048) begin
            step_bytes.push_back({3'b110, v[10:6]});
            step_bytes.push_back({2'b10, v[5:0]});
          end else begin
            step_bytes.push_back({4'b1110, v[15:12]});
            step_bytes.push_back({2'b10, v[11:6]});
            step_bytes.push_back({2'b10, v[5:0]});
          end
        end
        OUT_CP1251: step_bytes.push_back(ucs_to_cp1251(v));
        OUT_UTF16LE: begin
          step_bytes.push_back(v[7:0]);
          step_bytes.push_back(v[15:8]);
        end
        OUT_UTF16BE: begin
          step_bytes.push_back(v[15:8]);
          step_bytes.push_back(v[7:0]);
        end
        default: step_bytes.push_back(v[7:0]);
      endcase
    endfunction

    // accepted source byte: advance the decoder and queue its output bytes
    function void take_source(logic [7:0] b, logic last);
      logic [15:0] ch;
      bit          have;
      beat_t       nb;
      step_bytes.delete();
      ch   = '0;
      have = 1'b0;
      case (in_code)
        IN_UTF8: begin
          if (left == 2'd0) begin
            if (b >= 8'd192 && b <= 8'd223) begin
              partial = b - 8'd192;
              left    = 2'd1;
            end else if (b >= 8'd224 && b <= 8'd239) begin
              partial = b - 8'd224;
              left    = 2'd2;
            end else begin
              // ASCII and stray bytes stand for themselves
              ch   = {8'h00, b};
              have = 1'b1;
            end
          end else begin
            // continuation bytes are taken as they come, no marker check
            partial = (partial << 6) + b - 16'd128;
            left    = left - 2'd1;
            if (left == 2'd0) begin
              ch   = partial;
              have = 1'b1;
            end
          end
        end
        IN_CP1251: begin
          ch   = cp1251_to_ucs(b);
          have = 1'b1;
        end
        IN_UTF16LE: begin
          if (left == 2'd0) begin
            partial = {8'h00, b};
            left    = 2'd1;
          end else begin
            ch   = {b, partial[7:0]};
            left = 2'd0;
            have = 1'b1;
          end
        end
        default: begin
          ch   = {8'h00, b};
          have = 1'b1;
        end
      endcase

      // a character goes out whole as long as the budget is not yet used up
      if (have && sent < out_limit) begin
        encode(ch);
        count_out(step_bytes.size());
      end

      if (last) begin
        if (sent < out_limit) begin
          step_bytes.push_back(8'h00);
          count_out(1);
          if ((out_code == OUT_UTF16LE || out_code == OUT_UTF16BE) && sent < out_limit) begin
            step_bytes.push_back(8'h00);
            count_out(1);
          end
        end
        // a half-built character at the end of a string is dropped here
        partial = '0;
        left    = '0;
        sent    = '0;
      end

      foreach (step_bytes[i]) begin
        nb.data = step_bytes[i];
        nb.last = (i == step_bytes.size() - 1);
        due.push_back(nb);
      end
    endfunction

    function void match_output(logic [7:0] data, logic last);
      beat_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected output byte %02h (tlast %0b)", $time, data, last);
        errors++;
        return;
      end
      want = due.pop_front();
      if (data !== want.data) begin
        $display("%0t: out_byte mismatch: expected %02h, actual %02h", $time, want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: out_last mismatch: expected %0b, actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] in_byte
  logic        s_axis_tlast;    // in_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;    // [7:0] out_byte
  logic        m_axis_tlast;    // out_last
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  transcode_tracker tracker;
  beat_t            src_q[$];       // source bytes of the current phase
  logic [1:0]       cur_in;         // source encoding the generator follows
  bit               tx_quiet;       // sender runs without gaps while set
  bit               rx_quiet;       // receiver runs without stalls while set
  bit               hold_request;   // asks the receiver for one long stall

  codepage_transcoder uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Some tests failed");
    $finish;
  end

  // Every transfer is seen here at the rising edge. Register writes go in
  // first, then the source byte, then the output byte, so the outcome does
  // not hinge on process order within the step.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.load_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) tracker.take_source(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) tracker.match_output(m_axis_tdata, m_axis_tlast);
    end
  end

  // Output side: random stall before each transfer, quiet stretches with no
  // stalls, and one long hold-off on request so the job queue fills up and
  // the block has to push back on its input.
  initial begin : sink
    int stall;
    m_axis_tready = 1'b0;
    rx_quiet      = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  function void add(logic [7:0] b, logic last = 1'b0);
    beat_t nb;
    nb.data = b;
    nb.last = last;
    src_q.push_back(nb);
  endfunction

  // One character of the current source encoding, now and then a noise byte
  // (which in UTF-8 may be a stray or a lead that the string leaves open).
  function void add_char();
    int pick;
    pick = $urandom_range(0, 9);
    case (cur_in)
      IN_UTF8: begin
        if (pick < 3) begin
          add(8'($urandom_range(0, 127)));
        end else if (pick < 6) begin
          add(8'hC0 + 8'($urandom_range(0, 31)));
          add(8'h80 + 8'($urandom_range(0, 63)));
        end else if (pick < 9) begin
          add(8'hE0 + 8'($urandom_range(0, 15)));
          add(8'h80 + 8'($urandom_range(0, 63)));
          add(8'h80 + 8'($urandom_range(0, 63)));
        end else begin
          add(8'($urandom_range(0, 255)));
        end
      end
      IN_UTF16LE: begin
        add(8'($urandom_range(0, 255)));
        // mostly Cyrillic code units; a lone byte leaves a half unit open
        if (pick < 6) add(8'h04);
        else if (pick < 9) add(8'($urandom_range(0, 255)));
      end
      default: add(8'($urandom_range(0, 255)));
    endcase
  endfunction

  // one source byte; valid stays high into the next byte when no gap follows
  task automatic send_byte(beat_t nb);
    int gap;
    if ($urandom_range(0, 19) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= nb.data;
    s_axis_tlast  <= nb.last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic play_source();
    foreach (src_q[i]) send_byte(src_q[i]);
    src_q.delete();
  endtask

  // sender pauses until every predicted byte is out, then lets the block
  // settle, since a source byte may leave no output behind it
  task automatic drain_out();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // valid is left high; the caller lowers it after the last write
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // code registers get random upper bits to show they are masked off
  task automatic set_codes(logic [1:0] in_c, logic [2:0] out_c, logic [15:0] limit);
    write_reg(REG_IN_CODE, {14'($urandom), in_c});
    write_reg(REG_OUT_CODE, {13'($urandom), out_c});
    write_reg(REG_OUTPUT_LIMIT, limit);
    cfg_valid <= 1'b0;
    cur_in = in_c;
  endtask

  // random strings of characters and noise bytes, each closed by tlast
  task automatic random_phase(logic [1:0] in_c, logic [2:0] out_c, logic [15:0] limit,
                              bit hold);
    int nchars;
    set_codes(in_c, out_c, limit);
    while (src_q.size() < MIN_PHASE_BYTES) begin
      nchars = $urandom_range(1, 6);
      repeat (nchars) add_char();
      src_q[src_q.size() - 1].last = 1'b1;
    end
    if (hold) hold_request = 1'b1;
    play_source();
    drain_out();
  endtask

  initial begin
    logic [15:0] limit;
    int          sel;
    tracker       = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    tx_quiet      = 1'b0;
    hold_request  = 1'b0;
    cur_in        = IN_CODE_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset settings (UTF-8 in and out): ASCII ends, a two-byte
    // and the widest three-byte character, stray bytes, an unchecked
    // continuation, and a string cut off inside a sequence.
    add(8'h00); add(8'h7F);
    add(8'hD0); add(8'hB0);
    add(8'hEF); add(8'hBF); add(8'hBF);
    add(8'h80); add(8'hFF);
    add(8'hC3); add(8'h41);
    add(8'hE2); add(8'h82, 1'b1);
    play_source();
    drain_out();

    // CP1251 to UTF-16BE: Cyrillic block ends and the Ukrainian letters
    set_codes(IN_CP1251, OUT_UTF16BE, OUTPUT_LIMIT_RST);
    add(8'hC0); add(8'hFF); add(8'hB2); add(8'hAF); add(8'hB3); add(8'hBF);
    add(8'h41, 1'b1);
    play_source();
    drain_out();

    // UTF-16LE to CP1251 with a tight budget and an odd byte at the end
    set_codes(IN_UTF16LE, OUT_CP1251, 16'd3);
    add(8'h10); add(8'h04); add(8'h57); add(8'h04); add(8'h56, 1'b1);
    play_source();
    drain_out();

    // Random part. The first phase takes the long output hold-off.
    random_phase(IN_UTF8, OUT_UTF8, OUTPUT_LIMIT_RST, 1'b1);
    random_phase(IN_RAW, 3'($urandom_range(OUT_SPARE_LO, OUT_SPARE_HI)),
                 OUTPUT_LIMIT_RST, 1'b0);
    random_phase(IN_CP1251, OUT_UTF8, 16'($urandom_range(2, 9)), 1'b0);
    write_reg(REG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
    random_phase(IN_UTF16LE, OUT_UTF16LE, 16'd1, 1'b0);
    random_phase(IN_UTF8, OUT_UTF16BE, 16'd0, 1'b0);   // nothing may come out
    random_phase(IN_UTF8, OUT_CP1251, OUTPUT_LIMIT_RST, 1'b0);
    repeat (3) begin
      sel = $urandom_range(0, 3);
      if (sel < 2) limit = OUTPUT_LIMIT_RST;
      else if (sel == 2) limit = 16'($urandom_range(1, 16));
      else limit = 16'($urandom);
      random_phase(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), limit, 1'b0);
    end

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
